// ===== design/dirty_framebuffer_frame_sender_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dirty framebuffer frame sender
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIRTY_FRAMEBUFFER_FRAME_SENDER_ASSERT_SVH
`define DIRTY_FRAMEBUFFER_FRAME_SENDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dffs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DFFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dffs: next-cycle check failed");

`endif

// ===== design/dffs_pkg.sv =====
// ----------------------------------------------------------------------------
// dffs_pkg
// Types and constants shared by the frame sender controller and datapath.
// ----------------------------------------------------------------------------
package dffs_pkg;

   // Pixel store geometry: one byte holds eight horizontally adjacent pixels.
   localparam int STORE_DEPTH = 1024;
   localparam int STORE_AW    = 10;

   // Dirty marks are kept as 32-bit words, one bit per store byte.
   localparam int DIRTY_W     = 32;
   localparam int DIRTY_WORDS = 32;
   localparam int DIRTY_AW    = 5;
   localparam int DIRTY_BW    = 5;

   // A run never holds more than this many store bytes.
   localparam logic [4:0] RUN_LIMIT = 5'd20;

   // Frame bytes.
   localparam logic [7:0] BYTE_SOF  = 8'hAA;
   localparam logic [7:0] BYTE_EOF  = 8'hCC;
   localparam logic [7:0] BYTE_ESC  = 8'hFF;
   localparam logic [7:0] BYTE_TYPE = 8'h02;
   localparam logic [7:0] PIXEL_MSB = 8'h80;

   // Division of a 10-bit address by 3: multiply by 683, shift right by 11.
   localparam logic [9:0] DIV3_MUL   = 10'd683;
   localparam int         DIV3_SHIFT = 11;

   // The pixel offset start*8 has 13 bits. Row and column take two steps:
   // a reciprocal multiplication for the quotient, then a multiply-subtract
   // for the remainder.
   localparam int         DIV_W       = 13;
   localparam logic [3:0] DIV_STEPS   = 4'd2;
   localparam int         RECIP_SHIFT = 20;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_ALIGN_MUL,
      ST_ALIGN_LOAD,
      ST_DIV,
      ST_SOF,
      ST_TYPE,
      ST_TYPE_ESC,
      ST_ROW,
      ST_ROW_ESC,
      ST_COL,
      ST_COL_ESC,
      ST_RUN_RD,
      ST_RUN_CHK,
      ST_RUN_ESC
   } state_type;

   // What the output register loads.
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_SOF,
      EMIT_EOF,
      EMIT_DONE,
      EMIT_BODY,
      EMIT_XOR
   } emit_type;

   // Which body byte is currently being sent.
   typedef enum logic [1:0] {
      BODY_TYPE,
      BODY_ROW,
      BODY_COL,
      BODY_PIXEL
   } body_type;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_SCAN,
      RD_RUN
   } rd_src_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_CLEAR,
      WR_PIXEL,
      WR_RUN
   } wr_src_type;

   typedef struct packed {
      wr_src_type wr_src;
      logic       rd_en;
      rd_src_type rd_src;
      logic       req_load;
      logic       scan_clear;
      logic       scan_next;
      logic       found_load;
      logic       align_mul;
      logic       align_load;
      logic       div_step;
      logic       run_advance;
      emit_type   emit;
      body_type   body;
   } dp_cmd_type;

   typedef struct packed {
      logic req_send;
      logic req_in_range;
      logic clr_last;
      logic scan_hit;
      logic scan_last;
      logic div_last;
      logic run_stop;
      logic run_more;
      logic needs_esc;
   } dp_status_type;

endpackage

// ===== design/dffs_ram.sv =====
// ----------------------------------------------------------------------------
// dffs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dffs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dffs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dffs_ctrl
// Sequencer for the clearing pass, pixel updates, dirty scan and frame output.
// ----------------------------------------------------------------------------
module dffs_ctrl
   import dffs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing pass over the memories.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (status.req_send) begin
                  state_in = ST_SCAN_RD;
               end else if (status.req_in_range) begin
                  state_in = ST_PIX_WR;
               end
            end
         end
         ST_PIX_WR:     state_in = ST_IDLE;
         ST_SCAN_RD:    state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (status.scan_hit) begin
               state_in = ST_ALIGN_MUL;
            end else if (status.scan_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_ALIGN_MUL:  state_in = ST_ALIGN_LOAD;
         ST_ALIGN_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_SOF;
            end
         end
         ST_SOF:        state_in = ST_TYPE;
         ST_TYPE:       state_in = status.needs_esc ? ST_TYPE_ESC : ST_ROW;
         ST_TYPE_ESC:   state_in = ST_ROW;
         ST_ROW:        state_in = status.needs_esc ? ST_ROW_ESC : ST_COL;
         ST_ROW_ESC:    state_in = ST_COL;
         ST_COL:        state_in = status.needs_esc ? ST_COL_ESC : ST_RUN_RD;
         ST_COL_ESC:    state_in = ST_RUN_RD;
         ST_RUN_RD:     state_in = status.run_stop ? ST_IDLE : ST_RUN_CHK;
         ST_RUN_CHK: begin
            if (!status.run_more) begin
               state_in = ST_IDLE;
            end else if (status.needs_esc) begin
               state_in = ST_RUN_ESC;
            end else begin
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_ESC:    state_in = ST_RUN_RD;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd        = '0;
      cmd.wr_src = WR_NONE;
      cmd.rd_src = RD_REQ;
      cmd.emit   = EMIT_NONE;
      cmd.body   = BODY_TYPE;
      busy       = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_src = WR_CLEAR;
         end
         ST_IDLE: begin
            if (start) begin
               if (status.req_send) begin
                  cmd.scan_clear = 1'b1;
               end else if (status.req_in_range) begin
                  cmd.req_load = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_src   = RD_REQ;
               end
            end
         end
         ST_PIX_WR: begin
            cmd.wr_src = WR_PIXEL;
         end
         ST_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_SCAN;
         end
         ST_SCAN_CHK: begin
            if (status.scan_hit) begin
               cmd.found_load = 1'b1;
            end else if (status.scan_last) begin
               cmd.emit = EMIT_DONE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_ALIGN_MUL: begin
            cmd.align_mul = 1'b1;
         end
         ST_ALIGN_LOAD: begin
            cmd.align_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_SOF: begin
            cmd.emit = EMIT_SOF;
         end
         ST_TYPE: begin
            cmd.body = BODY_TYPE;
            cmd.emit = EMIT_BODY;
         end
         ST_TYPE_ESC: begin
            cmd.body = BODY_TYPE;
            cmd.emit = EMIT_XOR;
         end
         ST_ROW: begin
            cmd.body = BODY_ROW;
            cmd.emit = EMIT_BODY;
         end
         ST_ROW_ESC: begin
            cmd.body = BODY_ROW;
            cmd.emit = EMIT_XOR;
         end
         ST_COL: begin
            cmd.body = BODY_COL;
            cmd.emit = EMIT_BODY;
         end
         ST_COL_ESC: begin
            cmd.body = BODY_COL;
            cmd.emit = EMIT_XOR;
         end
         ST_RUN_RD: begin
            if (status.run_stop) begin
               cmd.emit = EMIT_EOF;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = RD_RUN;
            end
         end
         ST_RUN_CHK: begin
            cmd.body = BODY_PIXEL;
            if (status.run_more) begin
               cmd.emit   = EMIT_BODY;
               cmd.wr_src = WR_RUN;
               if (!status.needs_esc) begin
                  cmd.run_advance = 1'b1;
               end
            end else begin
               cmd.emit = EMIT_EOF;
            end
         end
         ST_RUN_ESC: begin
            cmd.body        = BODY_PIXEL;
            cmd.emit        = EMIT_XOR;
            cmd.run_advance = 1'b1;
         end
         default: begin
            cmd.emit = EMIT_NONE;
         end
      endcase
   end

endmodule

// ===== design/dffs_dpath.sv =====
// ----------------------------------------------------------------------------
// dffs_dpath
// Pixel store, dirty marks, scan, alignment, divider, run tracking and output.
// ----------------------------------------------------------------------------
module dffs_dpath
   import dffs_pkg::*;
#(
   parameter int DISPLAY_COLS = 128,
   parameter int DISPLAY_ROWS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_cmd,
   input  logic [5:0]    req_pixel_row,
   input  logic [6:0]    req_pixel_col,
   input  logic          req_pixel_on,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_frame_end,
   output logic          rsp_nothing_dirty
);

   localparam int ROW_BYTES  = DISPLAY_COLS / 8;
   localparam int USED_BYTES = DISPLAY_ROWS * ROW_BYTES;
   localparam int ADDR_EW    = STORE_AW + 1;
   localparam int RECIP_W    = 18;
   localparam int PROD_W     = DIV_W + RECIP_W;

   localparam logic [6:0]         ROWS_LIM = 7'(DISPLAY_ROWS);
   localparam logic [7:0]         COLS_LIM = 8'(DISPLAY_COLS);
   localparam logic [ADDR_EW-1:0] USED_LIM = ADDR_EW'(USED_BYTES);

   // Rounded-up reciprocal of the row width, exact for every 13-bit offset.
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / DISPLAY_COLS + 1);

   // Index of the lowest set bit of a dirty word.
   function automatic logic [DIRTY_BW-1:0] lowest_set(input logic [DIRTY_W-1:0] w);
      logic [DIRTY_BW-1:0] idx;
      idx = '0;
      for (int k = DIRTY_W - 1; k >= 0; k--) begin
         if (w[k]) begin
            idx = DIRTY_BW'(k);
         end
      end
      return idx;
   endfunction

   // Registers.
   logic [STORE_AW-1:0] clr_cnt_ff;
   logic [STORE_AW-1:0] pix_addr_ff;
   logic [2:0]          pix_bit_ff;
   logic                pix_on_ff;
   logic [DIRTY_AW-1:0] scan_idx_ff;
   logic [STORE_AW-1:0] first_ff;
   logic [19:0]         prod_ff;
   logic [DIV_W-1:0]    dividend_ff;
   logic [DIV_W-1:0]    quot_ff;
   logic [6:0]          rem_ff;
   logic [3:0]          div_cnt_ff;
   logic [ADDR_EW-1:0]  run_addr_ff;
   logic [4:0]          run_cnt_ff;
   logic [1:0]          phase_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_out_byte_ff;
   logic                rsp_frame_end_ff;
   logic                rsp_nothing_dirty_ff;

   // Memory ports.
   logic                pix_wr_en;
   logic [STORE_AW-1:0] pix_wr_addr;
   logic [7:0]          pix_wr_data;
   logic [STORE_AW-1:0] pix_rd_addr;
   logic [7:0]          pix_rd_data;
   logic                dirty_wr_en;
   logic [DIRTY_AW-1:0] dirty_wr_addr;
   logic [DIRTY_W-1:0]  dirty_wr_data;
   logic [DIRTY_AW-1:0] dirty_rd_addr;
   logic [DIRTY_W-1:0]  dirty_rd_data;

   // Combinational helpers.
   logic [ADDR_EW-1:0] req_addr;
   logic [7:0]         pix_mask;
   logic [7:0]         pix_new;
   logic [8:0]         third;
   logic [9:0]         start_addr;
   logic [PROD_W-1:0]  recip_prod;
   logic [DIV_W-1:0]   quot_cols;
   logic [DIV_W-1:0]   rem_full;
   logic [7:0]         col_next;
   logic [7:0]         body;

   // Store address of the requested pixel and its range check.
   assign req_addr = ADDR_EW'(req_pixel_row) * ADDR_EW'(ROW_BYTES)
                   + ADDR_EW'(req_pixel_col[6:3]);

   assign status.req_send     = req_cmd;
   assign status.req_in_range = ({1'b0, req_pixel_row} < ROWS_LIM)
                             && ({1'b0, req_pixel_col} < COLS_LIM)
                             && (req_addr < USED_LIM);

   // Latch the pixel request at acceptance.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         pix_addr_ff <= req_addr[STORE_AW-1:0];
         pix_bit_ff  <= req_pixel_col[2:0];
         pix_on_ff   <= req_pixel_on;
      end
   end

   // Read-modify-write value of the addressed store byte.
   assign pix_mask = PIXEL_MSB >> pix_bit_ff;
   assign pix_new  = pix_on_ff ? (pix_rd_data | pix_mask) : (pix_rd_data & ~pix_mask);

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.wr_src == WR_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clr_last = (clr_cnt_ff == STORE_AW'(STORE_DEPTH - 1));

   // Memory write and read port selection.
   always_comb begin
      pix_wr_en     = 1'b0;
      pix_wr_addr   = pix_addr_ff;
      pix_wr_data   = pix_new;
      dirty_wr_en   = 1'b0;
      dirty_wr_addr = pix_addr_ff[STORE_AW-1:DIRTY_BW];
      dirty_wr_data = dirty_rd_data | (DIRTY_W'(1) << pix_addr_ff[DIRTY_BW-1:0]);
      case (cmd.wr_src)
         WR_CLEAR: begin
            pix_wr_en     = 1'b1;
            pix_wr_addr   = clr_cnt_ff;
            pix_wr_data   = '0;
            dirty_wr_en   = 1'b1;
            dirty_wr_addr = clr_cnt_ff[DIRTY_AW-1:0];
            dirty_wr_data = '0;
         end
         WR_PIXEL: begin
            pix_wr_en   = 1'b1;
            dirty_wr_en = (pix_new != pix_rd_data);
         end
         WR_RUN: begin
            dirty_wr_en   = 1'b1;
            dirty_wr_addr = run_addr_ff[STORE_AW-1:DIRTY_BW];
            dirty_wr_data = dirty_rd_data
                          & ~(DIRTY_W'(1) << run_addr_ff[DIRTY_BW-1:0]);
         end
         default: begin
            pix_wr_en   = 1'b0;
            dirty_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      pix_rd_addr   = run_addr_ff[STORE_AW-1:0];
      dirty_rd_addr = run_addr_ff[STORE_AW-1:DIRTY_BW];
      case (cmd.rd_src)
         RD_REQ: begin
            pix_rd_addr   = req_addr[STORE_AW-1:0];
            dirty_rd_addr = req_addr[STORE_AW-1:DIRTY_BW];
         end
         RD_SCAN: begin
            dirty_rd_addr = scan_idx_ff;
         end
         default: begin
            dirty_rd_addr = run_addr_ff[STORE_AW-1:DIRTY_BW];
         end
      endcase
   end

   dffs_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr (pix_wr_addr),
      .wr_data (pix_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (pix_rd_addr),
      .rd_data (pix_rd_data)
   );

   dffs_ram #(
      .WIDTH (DIRTY_W),
      .DEPTH (DIRTY_WORDS)
   ) u_dirty_ram (
      .clock   (clock),
      .wr_en   (dirty_wr_en),
      .wr_addr (dirty_wr_addr),
      .wr_data (dirty_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (dirty_rd_addr),
      .rd_data (dirty_rd_data)
   );

   // Dirty word scan, lowest word first.
   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      if (cmd.found_load) begin
         first_ff <= {scan_idx_ff, lowest_set(dirty_rd_data)};
      end
   end

   assign status.scan_hit  = |dirty_rd_data;
   assign status.scan_last = (scan_idx_ff == DIRTY_AW'(DIRTY_WORDS - 1));

   // Align the first dirty address down to a multiple of three.
   assign third      = prod_ff[19:DIV3_SHIFT];
   assign start_addr = 10'(third) + {third, 1'b0};

   // Row and column of the start address: quotient by reciprocal
   // multiplication, then the remainder as offset minus quotient times width.
   assign recip_prod = PROD_W'(dividend_ff) * PROD_W'(RECIP);
   assign quot_cols  = quot_ff * DIV_W'(DISPLAY_COLS);
   assign rem_full   = dividend_ff - quot_cols;

   // Column of the next store byte, wrapping at the row width.
   always_comb begin
      col_next = {1'b0, rem_ff} + 8'd8;
      if (col_next >= COLS_LIM) begin
         col_next = col_next - COLS_LIM;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.align_mul) begin
         prod_ff <= 20'(first_ff) * 20'(DIV3_MUL);
      end
      if (cmd.align_load) begin
         dividend_ff <= {start_addr, 3'b000};
         quot_ff     <= '0;
         rem_ff      <= '0;
         div_cnt_ff  <= DIV_STEPS;
         run_addr_ff <= ADDR_EW'(start_addr);
         run_cnt_ff  <= '0;
         phase_ff    <= '0;
      end else if (cmd.div_step) begin
         if (div_cnt_ff == DIV_STEPS) begin
            quot_ff <= DIV_W'(recip_prod[PROD_W-1:RECIP_SHIFT]);
         end else begin
            rem_ff  <= rem_full[6:0];
         end
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end else if (cmd.run_advance) begin
         run_addr_ff <= run_addr_ff + 1'b1;
         run_cnt_ff  <= run_cnt_ff + 1'b1;
         phase_ff    <= (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
         rem_ff      <= col_next[6:0];
      end
   end

   assign status.div_last = (div_cnt_ff == 4'd1);

   // Run end and extension checks.
   assign status.run_stop = (run_addr_ff >= USED_LIM) || (run_cnt_ff >= RUN_LIMIT);
   assign status.run_more = (run_cnt_ff == '0) || (phase_ff != 2'd0)
                         || (dirty_rd_data[run_addr_ff[DIRTY_BW-1:0]] && (rem_ff != '0));

   // Body byte selection and escape detection.
   always_comb begin
      case (cmd.body)
         BODY_TYPE:  body = BYTE_TYPE;
         BODY_ROW:   body = quot_ff[7:0];
         BODY_COL:   body = {1'b0, rem_ff};
         BODY_PIXEL: body = pix_rd_data;
         default:    body = BYTE_TYPE;
      endcase
   end

   assign status.needs_esc = (body == BYTE_SOF) || (body == BYTE_EOF) || (body == BYTE_ESC);

   // Output register: one transfer per cycle with a strobe, in each cycle in which the controller emits a byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.emit != EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_end_ff     <= 1'b0;
      rsp_nothing_dirty_ff <= 1'b0;
      case (cmd.emit)
         EMIT_SOF: begin
            rsp_out_byte_ff <= BYTE_SOF;
         end
         EMIT_EOF: begin
            rsp_out_byte_ff  <= BYTE_EOF;
            rsp_frame_end_ff <= 1'b1;
         end
         EMIT_DONE: begin
            rsp_out_byte_ff      <= '0;
            rsp_frame_end_ff     <= 1'b1;
            rsp_nothing_dirty_ff <= 1'b1;
         end
         EMIT_BODY: begin
            rsp_out_byte_ff <= status.needs_esc ? BYTE_ESC : body;
         end
         EMIT_XOR: begin
            rsp_out_byte_ff <= body ^ BYTE_ESC;
         end
         default: begin
            rsp_out_byte_ff <= rsp_out_byte_ff;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_out_byte_ff;
   assign rsp_frame_end     = rsp_frame_end_ff;
   assign rsp_nothing_dirty = rsp_nothing_dirty_ff;

endmodule

// ===== design/dirty_framebuffer_frame_sender.sv =====
// ----------------------------------------------------------------------------
// dirty_framebuffer_frame_sender
// Monochrome framebuffer with per-byte dirty marks that sends dirty runs as
// byte-stuffed frames on a serial byte stream.
// ----------------------------------------------------------------------------
//   Channel   Ports                                        Transfer
//   request   start, busy, req_cmd, req_pixel_row/col/on   start high, busy low
//   response  rsp_valid, rsp_out_byte, rsp_frame_end,      rsp_valid high, one
//             rsp_nothing_dirty                            cycle, no back-pressure
//
// After reset a clearing pass zeroes the store and the dirty marks; busy
// stays high meanwhile. A pixel write is accepted, then does the
// read-modify-write of one store byte. A send scans the dirty words one at a
// time, with a read and a check per word of 32 marks, then aligns (multiply,
// then load) and finds row and column in the reciprocal divider, then emits
// the output bytes, with a read before each run byte and one more read when
// the run stops on a byte that it leaves out. Results are never held off.
// ----------------------------------------------------------------------------
module dirty_framebuffer_frame_sender
   import dffs_pkg::*;
#(
   parameter int DISPLAY_COLS = 128,
   parameter int DISPLAY_ROWS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [5:0] req_pixel_row,
   input  logic [6:0] req_pixel_col,
   input  logic       req_pixel_on,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_nothing_dirty
);

   `include "dirty_framebuffer_frame_sender_assert.svh"

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   dffs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (dp_cmd)
   );

   dffs_dpath #(
      .DISPLAY_COLS (DISPLAY_COLS),
      .DISPLAY_ROWS (DISPLAY_ROWS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_pixel_row     (req_pixel_row),
      .req_pixel_col     (req_pixel_col),
      .req_pixel_on      (req_pixel_on),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_nothing_dirty (rsp_nothing_dirty)
   );

   // The done result carries a zero byte and also ends the transfer sequence.
   `DFFS_ASSERT_SAME(a_done_form, clock, reset, rsp_valid && rsp_nothing_dirty, rsp_frame_end && (rsp_out_byte == 8'h00))

   // A frame end that is not the done result is the closing byte.
   `DFFS_ASSERT_SAME(a_eof_byte, clock, reset, rsp_valid && rsp_frame_end && !rsp_nothing_dirty, rsp_out_byte == BYTE_EOF)

   // Nothing follows the last result of a send in the next cycle.
   `DFFS_ASSERT_NEXT(a_gap_after_end, clock, reset, rsp_valid && rsp_frame_end, !rsp_valid)

   // An accepted send keeps the block busy in the following cycle.
   `DFFS_ASSERT_NEXT(a_send_busy, clock, reset, start && !busy && req_cmd, busy)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for dirty_framebuffer_frame_sender
// Drives pixel writes and send commands through the start/busy request port.
// Every accepted command is mirrored in a framebuffer model with dirty marks.
// The model turns each send into the expected stuffed frame bytes, and the
// response stream is checked against them byte by byte. A directed opening
// covers the done result, unchanged writes, escaped bytes, run extension, the
// row-start stop and the end of the store. Random pixel bursts with sends
// follow.
// ----------------------------------------------------------------------------
module tb_top;
   import dffs_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 6;
   localparam int COLS           = 128;
   localparam int ROWS           = 64;
   localparam int ROW_BYTES      = COLS / 8;
   localparam int USED_BYTES     = (ROWS * ROW_BYTES > STORE_DEPTH) ?
                                   STORE_DEPTH : ROWS * ROW_BYTES;
   localparam int TOTAL_ITEMS    = 212;
   localparam int DRAIN_CYCLES   = 300;
   localparam int TIMEOUT_CYCLES = 500000;

   // Command codes on req_cmd.
   localparam bit CMD_PIXEL = 1'b0;
   localparam bit CMD_SEND  = 1'b1;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       start             = 1'b0;
   logic       busy;
   logic       req_cmd           = 1'b0;
   logic [5:0] req_pixel_row     = '0;
   logic [6:0] req_pixel_col     = '0;
   logic       req_pixel_on      = 1'b0;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_end;
   logic       rsp_nothing_dirty;

   // One byte of the serial link as the block should present it.
   typedef struct {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       nothing_dirty;
   } link_byte_t;

   // Framebuffer mirror plus the queue of link bytes still to come.
   class frame_scoreboard;
      bit [7:0]   pixels [STORE_DEPTH];
      bit         dirty  [STORE_DEPTH];
      link_byte_t link_bytes_due[$];
      int         errors;

      function void push_link(bit [7:0] value, bit last, bit empty);
         link_byte_t item;
         item.out_byte      = value;
         item.frame_end     = last;
         item.nothing_dirty = empty;
         link_bytes_due.push_back(item);
      endfunction

      // Body bytes that collide with framing codes go out as escape plus xor.
      function void push_stuffed(bit [7:0] value);
         if (value == BYTE_SOF || value == BYTE_EOF || value == BYTE_ESC) begin
            push_link(BYTE_ESC, 1'b0, 1'b0);
            push_link(value ^ BYTE_ESC, 1'b0, 1'b0);
         end else begin
            push_link(value, 1'b0, 1'b0);
         end
      endfunction

      function void apply_command(bit cmd, bit [5:0] row, bit [6:0] col, bit on);
         int       addr;
         int       first;
         int       base;
         int       count;
         int       next;
         bit [7:0] mask;
         bit [7:0] updated;
         if (cmd == CMD_PIXEL) begin
            if (int'(row) >= ROWS || int'(col) >= COLS) return;
            addr = int'(row) * ROW_BYTES + int'(col) / 8;
            if (addr >= USED_BYTES) return;
            mask    = PIXEL_MSB >> (int'(col) % 8);
            updated = on ? (pixels[addr] | mask) : (pixels[addr] & ~mask);
            if (updated != pixels[addr]) dirty[addr] = 1'b1;
            pixels[addr] = updated;
            return;
         end
         // Send: locate the first dirty byte and align down to its group of 3.
         first = 0;
         while (first < USED_BYTES && !dirty[first]) first++;
         if (first >= USED_BYTES) begin
            push_link(8'h00, 1'b1, 1'b1);
            return;
         end
         base = first - first % 3;
         push_link(BYTE_SOF, 1'b0, 1'b0);
         push_stuffed(BYTE_TYPE);
         push_stuffed(8'((base * 8) / COLS));
         push_stuffed(8'((base * 8) % COLS));
         // The run covers the whole group, then grows group by group while the
         // next group opens on a dirty byte that is not at a row start.
         count = 0;
         forever begin
            push_stuffed(pixels[base + count]);
            dirty[base + count] = 1'b0;
            count++;
            next = base + count;
            if (next >= USED_BYTES || count >= int'(RUN_LIMIT)) break;
            if (next % 3 != 0) continue;
            if (dirty[next] && (next * 8) % COLS != 0) continue;
            break;
         end
         push_link(BYTE_EOF, 1'b1, 1'b0);
      endfunction

      function void check_result(logic [7:0] out_byte, logic frame_end,
                                 logic nothing_dirty);
         link_byte_t want;
         if (link_bytes_due.size() == 0) begin
            $error("unexpected result: out_byte %h frame_end %b nothing_dirty %b",
                   out_byte, frame_end, nothing_dirty);
            errors++;
            return;
         end
         want = link_bytes_due.pop_front();
         if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_byte);
            errors++;
         end
         if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, actual %b", want.frame_end, frame_end);
            errors++;
         end
         if (nothing_dirty !== want.nothing_dirty) begin
            $error("nothing_dirty: expected %b, actual %b",
                   want.nothing_dirty, nothing_dirty);
            errors++;
         end
      endfunction

      function int outstanding();
         return link_bytes_due.size();
      endfunction
   endclass

   frame_scoreboard sb;
   int              items_done = 0;
   bit              burst_mode = 1'b0;

   dirty_framebuffer_frame_sender #(
      .DISPLAY_COLS(COLS),
      .DISPLAY_ROWS(ROWS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_on     (req_pixel_on),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_nothing_dirty(rsp_nothing_dirty)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Each strobed response byte is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_out_byte, rsp_frame_end, rsp_nothing_dirty);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Present one command and hold it until the block takes the transfer.
   task automatic issue(bit cmd, bit [5:0] row, bit [6:0] col, bit on);
      int gap;
      gap = burst_mode ? 0 : idle_cycles();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= cmd;
      req_pixel_row <= row;
      req_pixel_col <= col;
      req_pixel_on  <= on;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.apply_command(cmd, row, col, on);
      items_done++;
   endtask

   task automatic write_pixel(int row, int col, bit on);
      issue(CMD_PIXEL, 6'(row), 7'(col), on);
   endtask

   // Pixel fields are don't-care on a send, so they carry random values.
   task automatic send_frame();
      issue(CMD_SEND, 6'($urandom), 7'($urandom), 1'($urandom));
   endtask

   task automatic wait_link_idle();
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int       kind;
      int       seq;
      int       count;
      int       sends;
      int       row;
      int       byte_col;
      int       r;
      int       c;
      bit [7:0] value;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening.
      send_frame();                  // empty framebuffer gives the done result
      write_pixel(0, 0, 1'b1);
      write_pixel(0, 0, 1'b1);       // no change, no new mark
      write_pixel(0, 2, 1'b1);
      write_pixel(0, 4, 1'b1);
      write_pixel(0, 6, 1'b1);       // byte 0 holds the start-of-frame code
      write_pixel(0, 8, 1'b1);
      write_pixel(0, 9, 1'b1);
      write_pixel(0, 12, 1'b1);
      write_pixel(0, 13, 1'b1);      // byte 1 holds the end-of-frame code
      write_pixel(0, 24, 1'b1);      // dirty byte 3 stretches the run
      send_frame();
      write_pixel(2, 104, 1'b1);
      write_pixel(3, 0, 1'b1);       // next group starts a row: run stops
      send_frame();
      send_frame();
      write_pixel(63, 112, 1'b1);
      write_pixel(63, 127, 1'b1);
      write_pixel(63, 127, 1'b0);    // back to zero but still marked
      send_frame();                  // run ends at the last byte of the store
      send_frame();
      write_pixel(0, 0, 1'b0);
      send_frame();

      // Random bursts of pixel writes, each followed by up to three sends.
      seq = 0;
      while (items_done < TOTAL_ITEMS) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         kind       = $urandom_range(0, 9);
         row        = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 63);
         byte_col   = $urandom_range(0, 15);
         if (kind < 2) begin
            // Fill a whole byte, favoring values that need escaping.
            case ($urandom_range(0, 3))
               0: value = BYTE_SOF;
               1: value = BYTE_EOF;
               2: value = BYTE_ESC;
               default: value = 8'($urandom);
            endcase
            for (int b = 0; b < 8; b++) write_pixel(row, byte_col * 8 + b, value[7 - b]);
         end else if (kind < 8) begin
            // Scatter pixels over a few neighboring bytes.
            count = $urandom_range(1, 6);
            for (int k = 0; k < count; k++) begin
               r = row;
               if ($urandom_range(0, 3) == 0 && row < 63) r = row + 1;
               c = byte_col * 8 + $urandom_range(0, 31);
               if (c > 127) c = 127;
               write_pixel(r, c, 1'($urandom));
            end
         end else if ($urandom_range(0, 1) == 1) begin
            write_pixel($urandom_range(0, 63), $urandom_range(0, 127), 1'($urandom));
         end
         sends = (kind < 8) ? $urandom_range(1, 3) : $urandom_range(0, 2);
         for (int k = 0; k < sends; k++) send_frame();
         seq++;
         if (seq == 12) wait_link_idle();
      end

      // Let the last frame drain, then watch for stray bytes.
      wait_link_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS dirty_framebuffer_frame_sender");
      end else begin
         $display("FAIL dirty_framebuffer_frame_sender");
      end
      $finish;
   end

   // Watchdog for a hung handshake or missing response bytes.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("FAIL dirty_framebuffer_frame_sender");
      $finish;
   end

endmodule

// ===== dirty_framebuffer_frame_sender.f =====
+incdir+design
design/dffs_pkg.sv
design/dffs_ram.sv
design/dffs_ctrl.sv
design/dffs_dpath.sv
design/dirty_framebuffer_frame_sender.sv
tb/tb_top.sv
